### rtl/lbs_pkg.sv
package lbs_pkg;

  localparam int unsigned CompBits     = 21;
  localparam int unsigned VecBits      = 3 * CompBits;
  localparam int unsigned WordsPerBone = 12;
  localparam int unsigned CarriedBones = 4;
  localparam int unsigned AccBits      = 64;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic signed [31:0]         mword_t;
  typedef logic signed [AccBits-1:0]  acc_t;

  // input and output words
  typedef struct packed {
    logic [VecBits-1:0] bind_tangent;
    logic [VecBits-1:0] bind_normal;
    logic [VecBits-1:0] bind_position;
    logic [63:0]        weights;
    logic [31:0]        bone_ids;
    logic [31:0]        load_value;
    logic [3:0]         load_slot;
    logic [7:0]         load_bone;
  } in_word_t;

  typedef struct packed {
    logic               saturated;
    logic [VecBits-1:0] skinned_tangent;
    logic [VecBits-1:0] skinned_normal;
    logic [VecBits-1:0] skinned_position;
  } out_word_t;

  typedef enum logic [0:0] {
    CmdLoad = 1'b0,
    CmdSkin = 1'b1
  } cmd_e;

  // floor-shift by 16 after adding half, from a wide row sum
  function automatic acc_t round16(input logic signed [AccBits-1:0] s);
    logic signed [AccBits-1:0] t;
    t = s + (acc_t'(1) <<< 15);
    return t >>> 16;
  endfunction

endpackage

### rtl/linear_blend_skinning_unit.sv
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: load_bone..bind_tangent
// m_axis    out        tdata: skinned_position..tangent; tuser: saturated
//
// A load word is written into the store as it is accepted. A vertex walks its bones one
// matrix row per cycle: per applied bone, a fetch then the three rows (three Q16.16
// multipliers per vector, one per operand); a skipped bone or the closing zero weight
// costs a fetch only. The weighting of each rounded row runs in the cycle after it, so
// a walk that ends on a row drains that row before the finish state.
// The bone store is one synchronous memory of 12*MAX_BONES words read as one
// 384-bit row per bone. Reset clears control only; the store holds garbage until
// loaded. Output is a register; a stalled result holds the next vertex in its
// finish state, and input waits behind that vertex.
module linear_blend_skinning_unit
  import lbs_pkg::*;
#(
  parameter int unsigned BONES_PER_VERTEX = 4,
  parameter int unsigned MAX_BONES        = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // load_bone[7:0], load_slot[11:8], load_value[43:12], bone_ids[75:44],
  // weights[139:76], bind_position[202:140], bind_normal[265:203],
  // bind_tangent[328:266], zero fill to 336
  input  logic [335:0]         s_axis_tdata,
  // command
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // skinned_position[62:0], skinned_normal[125:63], skinned_tangent[188:126],
  // zero fill to 192
  output logic [191:0]         m_axis_tdata,
  // saturated
  output logic                 m_axis_tuser
);

  localparam int unsigned BoneBits = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int unsigned Walk     = (BONES_PER_VERTEX < CarriedBones) ?
                                     BONES_PER_VERTEX : CarriedBones;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StFetch = 4'b0010,
    StRow   = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  typedef logic signed [39:0] row_t;
  typedef logic signed [16:0] wgt_t;

  // bone store, one 12-word row per bone
  logic [WordsPerBone*32-1:0] mem_q [MAX_BONES];
  logic [WordsPerBone*32-1:0] rd_q;

  state_e   state_q, state_d;
  in_word_t in_w, v_q;
  logic [1:0] k_q, k_d;
  logic [1:0] r_q, r_d;
  acc_t acc_q [9];
  acc_t acc_d [9];
  logic       ovld_q;
  out_word_t  out_q, out_d;

  // weighting stage: one rounded row in flight
  row_t       tp_q, tn_q, tt_q;
  wgt_t       tw_q;
  logic [1:0] tr_q;
  logic       tv_q;
  logic signed [56:0] pp, pn, pt;

  assign in_w = in_word_t'(s_axis_tdata[$bits(in_word_t)-1:0]);
  assign s_axis_tready = (state_q == StIdle);
  wire   take = s_axis_tvalid && s_axis_tready;

  wire [15:0] w_cur = v_q.weights[16*k_q +: 16];
  wire [7:0]  b_cur = v_q.bone_ids[8*k_q +: 8];
  wire        b_ok  = 32'(b_cur) < MAX_BONES;

  // memory write and registered row read
  always_ff @(posedge clk_i) begin
    if (take && cmd_e'(s_axis_tuser) == CmdLoad &&
        32'(in_w.load_bone) < MAX_BONES && in_w.load_slot < 4'(WordsPerBone)) begin
      mem_q[in_w.load_bone[BoneBits-1:0]][32*in_w.load_slot +: 32] <= in_w.load_value;
    end
    rd_q <= mem_q[b_cur[BoneBits-1:0]];
  end

  // row arithmetic: three dot products of one matrix row
  mword_t m0, m1, m2, m3;
  acc_t sp, sn, st;
  assign m0 = rd_q[32*(4*r_q+0) +: 32];
  assign m1 = rd_q[32*(4*r_q+1) +: 32];
  assign m2 = rd_q[32*(4*r_q+2) +: 32];
  assign m3 = rd_q[32*(4*r_q+3) +: 32];

  function automatic logic signed [53:0] dot3(mword_t a, mword_t b, mword_t c,
                                              logic [VecBits-1:0] v);
    logic signed [52:0] p0, p1, p2;
    p0 = a * comp_t'(v[CompBits-1:0]);
    p1 = b * comp_t'(v[2*CompBits-1:CompBits]);
    p2 = c * comp_t'(v[3*CompBits-1:2*CompBits]);
    return 54'(p0) + 54'(p1) + 54'(p2);
  endfunction

  assign sp = acc_t'(dot3(m0, m1, m2, v_q.bind_position)) + (acc_t'(m3) <<< 10);
  assign sn = acc_t'(dot3(m0, m1, m2, v_q.bind_normal));
  assign st = acc_t'(dot3(m0, m1, m2, v_q.bind_tangent));

  // weight products of the row in flight
  assign pp = tp_q * tw_q;
  assign pn = tn_q * tw_q;
  assign pt = tt_q * tw_q;

  // finish: round to Q10.10 and clamp
  function automatic logic [CompBits:0] fin(acc_t a);
    acc_t v;
    v = (a + acc_t'(16384)) >>> 15;
    if (v > acc_t'(1048575))       return {1'b1, 21'h0FFFFF};
    else if (v < -acc_t'(1048576)) return {1'b1, 21'h100000};
    else                           return {1'b0, v[CompBits-1:0]};
  endfunction

  logic [CompBits:0] f [9];
  always_comb begin
    for (int i = 0; i < 9; i++) f[i] = fin(acc_q[i]);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d = k_q;
    r_d = r_q;
    acc_d = acc_q;
    out_d = out_q;
    // accumulate the weighted row from the previous cycle
    if (tv_q) begin
      acc_d[4'(tr_q)]        = acc_q[4'(tr_q)]        + acc_t'(pp);
      acc_d[4'(tr_q) + 4'd3] = acc_q[4'(tr_q) + 4'd3] + acc_t'(pn);
      acc_d[4'(tr_q) + 4'd6] = acc_q[4'(tr_q) + 4'd6] + acc_t'(pt);
    end
    unique case (state_q)
      StIdle: begin
        if (take && cmd_e'(s_axis_tuser) == CmdSkin) begin
          for (int i = 0; i < 9; i++) acc_d[i] = '0;
          k_d = '0;
          state_d = StFetch;
        end
      end
      StFetch: begin
        r_d = '0;
        if (w_cur == 16'd0) state_d = StDone;
        else if (!b_ok) begin
          if (32'(k_q) == Walk - 1) state_d = StDone;
          else k_d = k_q + 2'd1;
        end else state_d = StRow;
      end
      StRow: begin
        if (r_q == 2'd2) begin
          if (32'(k_q) == Walk - 1) state_d = StDone;
          else begin
            k_d = k_q + 2'd1;
            state_d = StFetch;
          end
        end else r_d = r_q + 2'd1;
      end
      StDone: begin
        if (!tv_q && (!ovld_q || m_axis_tready)) begin
          out_d.skinned_position = {f[2][20:0], f[1][20:0], f[0][20:0]};
          out_d.skinned_normal   = {f[5][20:0], f[4][20:0], f[3][20:0]};
          out_d.skinned_tangent  = {f[8][20:0], f[7][20:0], f[6][20:0]};
          out_d.saturated = f[0][21] | f[1][21] | f[2][21] | f[3][21] | f[4][21] |
                            f[5][21] | f[6][21] | f[7][21] | f[8][21];
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) v_q <= in_w;
    acc_q <= acc_d;
    out_q <= out_d;
    k_q <= k_d;
    r_q <= r_d;
    tp_q <= row_t'(round16(sp));
    tn_q <= row_t'(round16(sn));
    tt_q <= row_t'(round16(st));
    tw_q <= wgt_t'({1'b0, w_cur});
    tr_q <= r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
      tv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tv_q    <= (state_q == StRow);
      if (state_q == StDone && !tv_q && (!ovld_q || m_axis_tready)) ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {3'b000, out_q.skinned_tangent, out_q.skinned_normal,
                          out_q.skinned_position};
  assign m_axis_tuser  = out_q.saturated;

`ifndef NO_ASSERTIONS
  // a result only follows the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == StDone))
    else $error("result without finish");
  // no input taken while walking bones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRow || state_q == StFetch) |-> !s_axis_tready)
    else $error("input accepted mid-vertex");
  // finish leaves only with output space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && ovld_q && !m_axis_tready) |=> state_q == StDone)
    else $error("result overwritten");
`endif

endmodule

### bench/linear_blend_skinning_unit_test.sv
module linear_blend_skinning_unit_test
  import lbs_pkg::*;
();

  localparam int unsigned NumBones  = 256;
  localparam int unsigned LimitCyc  = 400000;

  typedef struct packed {
    logic [62:0] pos;
    logic [62:0] nrm;
    logic [62:0] tan;
    logic        sat;
  } skin_out_t;

  typedef struct packed {
    cmd_e     cmd;
    in_word_t data;
  } stim_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [335:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [191:0] m_axis_tdata;

  linear_blend_skinning_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // clock
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // predictor state: mirror of the bone store
  logic signed [31:0] bone_mem [NumBones*12];
  bit                 bone_set [NumBones];  // bone fully loaded

  stim_t     pending_words[$];
  skin_out_t expected_skins[$];
  int        send_idle_pct, recv_stall_pct;
  int        errors, vertices_seen, loads_sent, cycles;

  function automatic logic signed [63:0] comp_at(logic [62:0] v, int c);
    logic signed [20:0] x;
    x = v[c*21 +: 21];
    return 64'(x);
  endfunction

  function automatic logic signed [63:0] round_down(logic signed [63:0] x, int s);
    logic signed [63:0] t;
    t = x + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  // blends up to four bones into one skinned vertex
  function automatic skin_out_t skin_vertex(in_word_t w);
    skin_out_t r;
    logic signed [63:0] p[3], n[3], t[3], ap[3], an[3], at[3];
    logic signed [63:0] m0, m1, m2, m3, wt, v;
    logic [62:0] outs[3];
    int b;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      p[c] = comp_at(w.bind_position, c);
      n[c] = comp_at(w.bind_normal, c);
      t[c] = comp_at(w.bind_tangent, c);
      ap[c] = 0; an[c] = 0; at[c] = 0;
    end
    for (int k = 0; k < 4; k++) begin
      wt = 64'(w.weights[16*k +: 16]);
      b = w.bone_ids[8*k +: 8];
      if (wt == 0) break;
      if (b >= NumBones) continue;
      for (int row = 0; row < 3; row++) begin
        m0 = 64'(bone_mem[b*12 + row*4]);
        m1 = 64'(bone_mem[b*12 + row*4 + 1]);
        m2 = 64'(bone_mem[b*12 + row*4 + 2]);
        m3 = 64'(bone_mem[b*12 + row*4 + 3]);
        ap[row] += round_down(m0*p[0] + m1*p[1] + m2*p[2] + m3*1024, 16) * wt;
        an[row] += round_down(m0*n[0] + m1*n[1] + m2*n[2], 16) * wt;
        at[row] += round_down(m0*t[0] + m1*t[1] + m2*t[2], 16) * wt;
      end
    end
    outs = '{default: '0};
    for (int c = 0; c < 3; c++) begin
      for (int q = 0; q < 3; q++) begin
        v = round_down(q == 0 ? ap[c] : q == 1 ? an[c] : at[c], 15);
        if (v > 64'sd1048575) begin v = 1048575; r.sat = 1'b1; end
        if (v < -64'sd1048576) begin v = -1048576; r.sat = 1'b1; end
        outs[q][c*21 +: 21] = v[20:0];
      end
    end
    r.pos = outs[0]; r.nrm = outs[1]; r.tan = outs[2];
    return r;
  endfunction

  function automatic logic [62:0] rand_vec(int mode);
    logic [62:0] v;
    for (int c = 0; c < 3; c++)
      case (mode)
        0: v[c*21 +: 21] = 21'($urandom);
        1: v[c*21 +: 21] = 21'(int'($urandom_range(0, 4096)) - 2048);
        2: v[c*21 +: 21] = $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
        default: v[c*21 +: 21] = 21'(int'($urandom_range(0, 2048)) - 1024);
      endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_mword(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 131072)) - 65536);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // queue one load word; the driver mirrors it in the predictor store at hand-off
  task automatic push_load(int b, int slot, logic [31:0] val);
    stim_t s;
    logic [351:0] junk;
    s = '0;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    s.data = junk[$bits(in_word_t)-1:0];
    s.cmd = CmdLoad;
    s.data.load_bone = b[7:0];
    s.data.load_slot = slot[3:0];
    s.data.load_value = val;
    pending_words.push_back(s);
  endtask

  task automatic push_bone(int b, int mode);
    for (int sl = 0; sl < 12; sl++) push_load(b, sl, rand_mword(mode));
    bone_set[b] = 1'b1;
  endtask

  function automatic int pick_bone();
    int b;
    do b = $urandom_range(0, NumBones - 1); while (!bone_set[b]);
    return b;
  endfunction

  task automatic push_vertex(logic [31:0] ids, logic [63:0] wts, int vmode);
    stim_t s;
    logic [351:0] junk;
    s.cmd = CmdSkin;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    s.data = junk[$bits(in_word_t)-1:0];
    s.data.bone_ids = ids;
    s.data.weights = wts;
    s.data.bind_position = rand_vec(vmode);
    s.data.bind_normal = rand_vec(vmode);
    s.data.bind_tangent = rand_vec(vmode);
    pending_words.push_back(s);
  endtask

  // random vertex: only loaded bones are read up to the first zero weight
  task automatic push_rand_vertex();
    logic [31:0] ids;
    logic [63:0] wts;
    int nb;
    nb = $urandom_range(0, 4);
    ids = $urandom;
    wts = {$urandom, $urandom};
    for (int k = 0; k < 4; k++) begin
      if (k < nb) begin
        ids[8*k +: 8] = 8'(pick_bone());
        case ($urandom_range(0, 3))
          0: wts[16*k +: 16] = 16'($urandom_range(1, 65535));
          1: wts[16*k +: 16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
          default: wts[16*k +: 16] = 16'($urandom_range(1, 32768 / (nb > 0 ? nb : 1)));
        endcase
      end else if (k == nb) begin
        wts[16*k +: 16] = '0;
      end
    end
    push_vertex(ids, wts, $urandom_range(0, 3));
  endtask

  // driver: presents queued words, idles at random between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        stim_t s;
        s = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, s.data};
        s_axis_tuser  <= s.cmd;
        // predict at hand-off: the store update is in order with vertices
        if (s.cmd == CmdLoad) begin
          if (s.data.load_slot < 12 && int'(s.data.load_bone) < NumBones)
            bone_mem[s.data.load_bone*12 + s.data.load_slot] = s.data.load_value;
          loads_sent++;
        end else begin
          expected_skins.push_back(skin_vertex(s.data));
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: stalls at random, checks each result word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        skin_out_t e;
        vertices_seen++;
        if (expected_skins.size() == 0) begin
          $display("%0t: unexpected result pos=%h", $time, m_axis_tdata[62:0]);
          errors++;
        end else begin
          e = expected_skins.pop_front();
          if (m_axis_tdata[62:0] !== e.pos) begin
            $display("%0t: position exp %h got %h", $time, e.pos, m_axis_tdata[62:0]);
            errors++;
          end
          if (m_axis_tdata[125:63] !== e.nrm) begin
            $display("%0t: normal exp %h got %h", $time, e.nrm, m_axis_tdata[125:63]);
            errors++;
          end
          if (m_axis_tdata[188:126] !== e.tan) begin
            $display("%0t: tangent exp %h got %h", $time, e.tan, m_axis_tdata[188:126]);
            errors++;
          end
          if (m_axis_tuser !== e.sat) begin
            $display("%0t: saturated exp %b got %b", $time, e.sat, m_axis_tuser);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCyc) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme matrices, identity, ignored loads, special walks
    push_bone(0, 2);
    push_bone(255, 3);
    for (int sl = 0; sl < 12; sl++)
      push_load(1, sl, (sl % 5 == 0) ? 32'h00010000 : 32'h0);
    bone_set[1] = 1'b1;
    push_load(1, 12, 32'hDEADBEEF);
    push_load(1, 15, 32'hFFFFFFFF);
    push_vertex(32'h0000_0001, 64'h0000_0000_0000_8000, 1);   // identity
    push_vertex(32'h0101_0101, 64'h2000_2000_2000_2000, 2);   // four bones
    push_vertex(32'hFF00_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 2);   // saturating
    push_vertex(32'hFFFF_FFFF, 64'h0000_0000_0000_0000, 0);   // first weight zero
    push_vertex(32'h0000_FF01, 64'h1234_0000_8000_0001, 3);   // stops early
    push_vertex(32'hFF01_0100, 64'h0001_0001_0001_0001, 1);
    for (int v = 0; v < 5; v++) push_rand_vertex();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      while (pending_words.size() != 0) @(posedge clk_i);
      send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 32 : 0;
      for (int b = 0; b < 6; b++) push_bone($urandom_range(0, 255), $urandom_range(0, 3));
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(0, 15) == 0)
          push_load($urandom_range(0, 255), $urandom_range(12, 15), $urandom);
        else if ($urandom_range(0, 20) == 0)
          push_bone($urandom_range(0, 255), $urandom_range(0, 3));
        else
          push_rand_vertex();
      end
    end
    while (pending_words.size() != 0 || s_axis_tvalid || expected_skins.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("checked %0d skinned vertices after %0d matrix word loads", vertices_seen,
             loads_sent);
    if (errors == 0 && expected_skins.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
